>>> src/assert_macros.svh
// assertion macros shared by the rtl, clocked on clk with rst_n low disabling checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/qde_pkg.sv
// types and constants of the quotient digit estimator
package qde_pkg;

  localparam int unsigned FIELD_BITS = 32;
  // digit width, 8 to 32; field bits above it are ignored
  localparam int unsigned DIGIT_BITS = 32;
  localparam int unsigned CNT_BITS   = $clog2(2 * DIGIT_BITS + 1);

  typedef logic [FIELD_BITS-1:0]     field_t;
  typedef logic [DIGIT_BITS-1:0]     digit_t;
  typedef logic [2*DIGIT_BITS-1:0]   dword_t;
  typedef logic [CNT_BITS-1:0]       cnt_t;

  typedef struct packed {
    field_t upper_digit;
    field_t middle_digit;
    field_t lower_digit;
    field_t divisor_high;
    field_t divisor_low;
  } qde_in_t;

  typedef struct packed {
    field_t quotient_digit;
    logic   bad_operands;
  } qde_out_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } qde_state_t;

endpackage

>>> src/quotient_digit_estimator_unit.sv
// trial quotient digit of long division with bit-serial dividers
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------
//  in_     | input     | in_valid/in_ready  | qde_pkg::qde_in_t
//  out_    | output    | out_valid/out_ready| qde_pkg::qde_out_t
//
// one item at a time: a load, then one quotient bit per cycle, then delivery
// usual case one digit of quotient bits; upper digit above divisor top digit
// two digits of quotient bits; zero divisor digit skips the divide
// the dividers step through the shared shift register, one dividend bit a cycle
// rst_n is synchronous and active low; it clears the sequencer and the output valid
// a finished result waits in the output register; a new item is taken meanwhile,
// but a second result holds the sequencer until the register is free
`include "assert_macros.svh"

module quotient_digit_estimator_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qde_pkg::qde_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qde_pkg::qde_out_t out_data
);

  // for v1 != 0 and u2 <= v1 the digit is max(q_min, min(radix - 1, floor(U / V))) where
  //   U = three dividend digits, V = two divisor digits
  //   q_min = floor((two upper digits - radix) / divisor_high), the point at which
  //   the running remainder would reach the radix and corrections stop
  // divider a forms q_min, divider b forms floor(U / V); they share one shift register

  // sequencer
  qde_pkg::qde_state_t state_r, state_nxt;
  qde_pkg::cnt_t       cnt_r, cnt_nxt;
  logic                step_en;
  logic                finish;
  logic                accept;

  // operand decode at load
  qde_pkg::digit_t u2, u1, u0, v1, v0, u2_m1;
  qde_pkg::dword_t num, vv;
  logic            zero_div, upper_big, long_div, sat_in;

  // datapath registers
  qde_pkg::dword_t sh_r, sh_nxt;           // dividend bits, msb first
  qde_pkg::dword_t vv_r;                   // divisor digits joined
  qde_pkg::digit_t a_rem_r, a_rem_nxt;
  qde_pkg::digit_t a_q_r, a_q_nxt;
  qde_pkg::dword_t b_rem_r, b_rem_nxt;
  qde_pkg::digit_t b_q_r, b_q_nxt;
  logic            zero_r, bad_r, long_r, sat_r, min_ok_r;

  // divider step logic
  logic [qde_pkg::DIGIT_BITS:0]   a_t, a_diff, a_dvs;
  logic [2*qde_pkg::DIGIT_BITS:0] b_t, b_diff, b_dvs;
  logic                           a_ge, b_ge;

  // result
  qde_pkg::digit_t   b_sat, q_sel;
  qde_pkg::qde_out_t out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign accept = in_valid && in_ready;

  // operand decode
  always_comb begin
    u2        = in_data.upper_digit[qde_pkg::DIGIT_BITS-1:0];
    u1        = in_data.middle_digit[qde_pkg::DIGIT_BITS-1:0];
    u0        = in_data.lower_digit[qde_pkg::DIGIT_BITS-1:0];
    v1        = in_data.divisor_high[qde_pkg::DIGIT_BITS-1:0];
    v0        = in_data.divisor_low[qde_pkg::DIGIT_BITS-1:0];
    u2_m1     = u2 - 1'b1;
    num       = {u2, u1};
    vv        = {v1, v0};
    zero_div  = (v1 == '0);
    upper_big = (u2 > v1);
    // q_min needs two digits of quotient only when the upper digit is too large
    long_div  = !zero_div && upper_big;
    // floor(U / V) reaches the radix exactly when the upper two digits reach V
    sat_in    = (num >= vv);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qde_pkg::ST_IDLE: begin
        if (accept) state_nxt = qde_pkg::ST_RUN;
      end
      qde_pkg::ST_RUN: begin
        if (finish) state_nxt = qde_pkg::ST_IDLE;
      end
      default: state_nxt = qde_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    step_en  = 1'b0;
    finish   = 1'b0;
    unique case (state_r)
      qde_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      qde_pkg::ST_RUN: begin
        step_en = (cnt_r != '0);
        // hold the finished digit until the output register is free
        finish  = (cnt_r == '0) && (!out_valid_r || out_ready);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // divider a: remainder stays below divisor_high
  always_comb begin
    a_t       = {a_rem_r, sh_r[2*qde_pkg::DIGIT_BITS-1]};
    a_dvs     = {1'b0, vv_r[2*qde_pkg::DIGIT_BITS-1:qde_pkg::DIGIT_BITS]};
    a_diff    = a_t - a_dvs;
    a_ge      = (a_t >= a_dvs);
    a_rem_nxt = a_ge ? a_diff[qde_pkg::DIGIT_BITS-1:0] : a_t[qde_pkg::DIGIT_BITS-1:0];
    a_q_nxt   = {a_q_r[qde_pkg::DIGIT_BITS-2:0], a_ge};
  end

  // divider b: takes the lower dividend digit from the low half of the shift register
  always_comb begin
    b_t       = {b_rem_r, sh_r[qde_pkg::DIGIT_BITS-1]};
    b_dvs     = {1'b0, vv_r};
    b_diff    = b_t - b_dvs;
    b_ge      = (b_t >= b_dvs);
    b_rem_nxt = b_ge ? b_diff[2*qde_pkg::DIGIT_BITS-1:0] : b_t[2*qde_pkg::DIGIT_BITS-1:0];
    b_q_nxt   = {b_q_r[qde_pkg::DIGIT_BITS-2:0], b_ge};
    sh_nxt    = {sh_r[2*qde_pkg::DIGIT_BITS-2:0], 1'b0};
  end

  // load or step count
  always_comb begin
    cnt_nxt = cnt_r;
    priority if (accept) begin
      if (zero_div) begin
        cnt_nxt = '0;
      end else if (long_div) begin
        cnt_nxt = qde_pkg::CNT_BITS'(2 * qde_pkg::DIGIT_BITS);
      end else begin
        cnt_nxt = qde_pkg::CNT_BITS'(qde_pkg::DIGIT_BITS);
      end
    end else if (step_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // result selection
  always_comb begin
    b_sat = sat_r ? '1 : b_q_r;
    priority if (zero_r) begin
      q_sel = '1;                        // all-ones digit for a zero divisor digit
    end else if (long_r) begin
      q_sel = a_q_r;                     // q_min is above the radix, low digit wins
    end else if (min_ok_r && (a_q_r > b_sat)) begin
      q_sel = a_q_r;                     // corrections stopped by remainder overflow
    end else begin
      q_sel = b_sat;
    end
    out_nxt.quotient_digit = qde_pkg::FIELD_BITS'(q_sel);
    out_nxt.bad_operands   = bad_r;
    out_valid_nxt = finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qde_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      vv_r     <= vv;
      zero_r   <= zero_div;
      bad_r    <= zero_div || upper_big;
      long_r   <= long_div;
      sat_r    <= sat_in;
      min_ok_r <= (u2 != '0);
      // long: divide {u2 - 1, u1} over two digits; else start from u2 - 1 with u1, u0 below
      sh_r     <= long_div ? {u2_m1, u1} : {u1, u0};
      a_rem_r  <= (long_div || (u2 == '0)) ? '0 : u2_m1;
      a_q_r    <= '0;
      b_rem_r  <= num;
      b_q_r    <= '0;
    end else if (step_en) begin
      sh_r    <= sh_nxt;
      a_rem_r <= a_rem_nxt;
      a_q_r   <= a_q_nxt;
      b_rem_r <= b_rem_nxt;
      b_q_r   <= b_q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `QDE_ASSERT_NEXT(a_zero_div_skips, accept && (in_data.divisor_high[qde_pkg::DIGIT_BITS-1:0] == '0), cnt_r == '0, "zero divisor digit did not skip the divide")
  `QDE_ASSERT_NEXT(a_cnt_steps, (state_r == qde_pkg::ST_RUN) && (cnt_r != '0), cnt_r == ($past(cnt_r) - 1'b1), "bit counter did not step by one")
  `QDE_ASSERT_NOW(a_short_len, (state_r == qde_pkg::ST_RUN) && !long_r, cnt_r <= qde_pkg::CNT_BITS'(qde_pkg::DIGIT_BITS), "single-digit divide runs too long")
  `QDE_ASSERT_NOW(a_rem_bound, (state_r == qde_pkg::ST_RUN) && !zero_r, a_rem_r < vv_r[2*qde_pkg::DIGIT_BITS-1:qde_pkg::DIGIT_BITS], "divider remainder not below divisor digit")

endmodule
